@@ sv/klvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klvp_pkg
// shared types, constants and tag table for the telemetry field parser
// ----------------------------------------------------------------------------
package klvp_pkg;

    localparam int KeyMaxBytes = 16;
    localparam int RecentDepth = 15;

    localparam logic [7:0] KeySearchLimitReset  = 8'd100;
    localparam logic [2:0] LengthSkipBytesReset = 3'd2;

    // configuration register indexes
    localparam logic CfgKeySearchLimit  = 1'b0;
    localparam logic CfgLengthSkipBytes = 1'b1;

    // telemetry universal key
    localparam logic [7:0] TeleKey [KeyMaxBytes] = '{
        8'h06, 8'h0E, 8'h2B, 8'h34, 8'h02, 8'h0B, 8'h01, 8'h01,
        8'h0E, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_SKIP   = 3'd1,
        PH_TAG    = 3'd2,
        PH_LEN    = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [63:0] field_value;
        logic [3:0]  value_width;
        logic        length_mismatch;
    } t_field_result;

    // value width in bytes of a recognized tag, zero when unknown
    function automatic logic [3:0] tag_width(input logic [7:0] tag);
        logic [3:0] w;
        unique case (tag)
            8'd2:                                   w = 4'd8;
            8'd1, 8'd5, 8'd6, 8'd7,
            8'd15, 8'd16, 8'd17:                    w = 4'd2;
            8'd13, 8'd14, 8'd18, 8'd19, 8'd20:      w = 4'd4;
            default:                                w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

@@ sv/klvp_key_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klvp_key_window
// shift line of recent bytes and key compare against the current byte
// ----------------------------------------------------------------------------
module klvp_key_window #(
    parameter int KEY_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_key_hit
);
    import klvp_pkg::*;

    logic [7:0] r_recent [RecentDepth];
    logic       tail_ok;

    always_comb begin
        tail_ok = 1'b1;
        for (int j = 1; j < RecentDepth + 1; j++) begin
            if (j < KEY_BYTES) begin
                if (r_recent[j - 1] != TeleKey[4'(KEY_BYTES - 1 - j)]) begin
                    tail_ok = 1'b0;
                end
            end
        end
    end

    assign o_key_hit = tail_ok && (i_byte == TeleKey[4'(KEY_BYTES - 1)]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RecentDepth; k++) begin
                r_recent[k] <= 8'd0;
            end
        end else if (i_step) begin
            r_recent[0] <= i_byte;
            for (int k = 1; k < RecentDepth; k++) begin
                r_recent[k] <= r_recent[k - 1];
            end
        end
    end

endmodule

@@ sv/klvp_item_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klvp_item_walker
// packet offset tracking and tag / length / value walk, one byte per step
// ----------------------------------------------------------------------------
module klvp_item_walker #(
    parameter int PACKET_BYTES = 188,
    parameter int KEY_BYTES    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic                    i_key_hit,
    input  logic [7:0]              i_key_search_limit,
    input  logic [2:0]              i_length_skip_bytes,
    output logic                    o_result_valid,
    output klvp_pkg::t_field_result o_result
);
    import klvp_pkg::*;

    localparam logic [7:0] LastOffset = 8'(PACKET_BYTES - 1);
    localparam logic [8:0] KeyTail    = 9'(KEY_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_offset, n_offset;
    logic [2:0]  r_skip, n_skip;
    logic [7:0]  r_tag, n_tag;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_seen, n_seen;
    logic [63:0] r_accum, n_accum;

    t_phase      eff_phase;
    logic [7:0]  eff_offset;
    logic        eff_last;
    logic        window_ok;
    logic [8:0]  key_start;
    logic [3:0]  width_cur;
    logic [7:0]  seen_inc;
    logic        finish;

    assign width_cur = tag_width(r_tag);
    assign seen_inc  = r_seen + 8'd1;

    always_comb begin
        eff_phase  = i_first ? PH_SEARCH : r_phase;
        eff_offset = i_first ? 8'd0 : r_offset;
        eff_last   = i_last || (eff_offset >= LastOffset);
        key_start  = {1'b0, eff_offset} - KeyTail;
        window_ok  = ({1'b0, eff_offset} >= KeyTail)
                     && (key_start < {1'b0, i_key_search_limit});

        n_phase  = eff_phase;
        n_skip   = r_skip;
        n_tag    = r_tag;
        n_length = r_length;
        n_seen   = r_seen;
        n_accum  = r_accum;
        finish   = 1'b0;

        unique case (eff_phase)
            PH_SEARCH: begin
                if (window_ok && i_key_hit) begin
                    n_skip  = i_length_skip_bytes;
                    n_phase = (i_length_skip_bytes == 3'd0) ? PH_TAG : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 3'd1;
                if (n_skip == 3'd0) begin
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                n_tag   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_length = i_byte;
                n_seen   = 8'd0;
                n_accum  = 64'd0;
                if (i_byte == 8'd0) begin
                    finish  = 1'b1;
                    n_phase = PH_TAG;
                end else begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (r_seen < {4'd0, width_cur}) begin
                    n_accum = {r_accum[55:0], i_byte};
                end
                n_seen = seen_inc;
                if (seen_inc == r_length) begin
                    finish  = 1'b1;
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase

        if (eff_last) begin
            n_offset = 8'd0;
            n_phase  = PH_SEARCH;
        end else if (eff_offset != 8'hFF) begin
            n_offset = eff_offset + 8'd1;
        end else begin
            n_offset = eff_offset;
        end
    end

    // result uses the tag held from the tag byte and the updated length and value
    always_comb begin
        o_result_valid           = finish && (width_cur != 4'd0);
        o_result.field_tag       = r_tag[4:0];
        o_result.field_value     = n_accum;
        o_result.value_width     = width_cur;
        o_result.length_mismatch = (n_length != {4'd0, width_cur});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_offset <= 8'd0;
            r_skip   <= 3'd0;
            r_tag    <= 8'd0;
            r_length <= 8'd0;
            r_seen   <= 8'd0;
            r_accum  <= 64'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_skip   <= n_skip;
            r_tag    <= n_tag;
            r_length <= n_length;
            r_seen   <= n_seen;
            r_accum  <= n_accum;
        end
    end

endmodule

@@ sv/klv_telemetry_field_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klv_telemetry_field_parser
// extracts telemetry local set fields from transport packet payload bytes
// ----------------------------------------------------------------------------
// Payload bytes enter one beat per cycle, marked with packet_first and
// packet_last. In each packet the parser looks for the 16-byte telemetry key
// starting below offset key_search_limit, skips length_skip_bytes bytes of set
// length, then walks tag/length/value items to the packet end. Each complete
// item with a recognized tag (1, 2, 5-7, 13-20) produces one output beat with
// the tag, its big-endian value cut to the tag width, the width and a length
// mismatch flag; other items and items cut off by the packet end give nothing.
// A byte is held in an input register, walked through one stage of logic and
// its result lands in an output register, one byte per cycle sustained, with
// input stall raised only while a byte is held and a result waits downstream
// under output stall. The user must write configuration only while the
// parser is idle; the parser itself does not enforce this.
// ----------------------------------------------------------------------------
module klv_telemetry_field_parser #(
    parameter int PACKET_BYTES = 188,
    parameter int KEY_BYTES    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_first,
    input  logic        i_packet_last,
    // field output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_field_tag,
    output logic [63:0] o_field_value,
    output logic [3:0]  o_value_width,
    output logic        o_length_mismatch
);
    import klvp_pkg::*;

    // configuration registers
    logic [7:0]    r_key_search_limit;
    logic [2:0]    r_length_skip_bytes;

    // input register
    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_first;
    logic          r_last;

    // output register
    logic          r_out_valid;
    t_field_result r_out;

    logic          step;
    logic          in_take;
    logic          key_hit;
    logic          result_valid;
    t_field_result result;

    // held byte is walked when the output register is free or being drained
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_search_limit  <= KeySearchLimitReset;
            r_length_skip_bytes <= LengthSkipBytesReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgKeySearchLimit:  r_key_search_limit  <= i_cfg_data;
                CfgLengthSkipBytes: r_length_skip_bytes <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte  <= i_data_byte;
            r_first <= i_packet_first;
            r_last  <= i_packet_last;
        end
    end

    klvp_key_window #(
        .KEY_BYTES (KEY_BYTES)
    ) u_key_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_byte),
        .o_key_hit (key_hit)
    );

    klvp_item_walker #(
        .PACKET_BYTES (PACKET_BYTES),
        .KEY_BYTES    (KEY_BYTES)
    ) u_item_walker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (step),
        .i_byte              (r_byte),
        .i_first             (r_first),
        .i_last              (r_last),
        .i_key_hit           (key_hit),
        .i_key_search_limit  (r_key_search_limit),
        .i_length_skip_bytes (r_length_skip_bytes),
        .o_result_valid      (result_valid),
        .o_result            (result)
    );

    // output register: refilled on every step, emptied when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= result_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_field_tag       = r_out.field_tag;
    assign o_field_value     = r_out.field_value;
    assign o_value_width     = r_out.value_width;
    assign o_length_mismatch = r_out.length_mismatch;

endmodule

@@ test/klv_field_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klv_field_checker
// tracks the parser state from accepted byte beats and checks each field beat
// ----------------------------------------------------------------------------
module klv_field_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_first,
    input  logic        i_packet_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_field_tag,
    input  logic [63:0] i_field_value,
    input  logic [3:0]  i_value_width,
    input  logic        i_length_mismatch,
    output int          o_fail_count,
    output int          o_pending
);
    import klvp_pkg::*;

    localparam logic [7:0] LastOffset = 8'd187;

    t_field_result expected_fields[$];
    int            fail_total;

    logic [7:0]  search_limit;
    logic [2:0]  skip_setting;
    logic [7:0]  history [RecentDepth];
    logic [7:0]  offset;
    t_phase      phase;
    logic [2:0]  skip_left;
    logic [7:0]  tag_byte;
    logic [7:0]  item_len;
    logic [7:0]  seen;
    logic [63:0] accum;

    initial begin
        fail_total = 0;
    end

    function automatic int unsigned tag_bytes(input logic [7:0] tag);
        case (tag)
            8'd2:                                  return 8;
            8'd1, 8'd5, 8'd6, 8'd7,
            8'd15, 8'd16, 8'd17:                   return 2;
            8'd13, 8'd14, 8'd18, 8'd19, 8'd20:     return 4;
            default:                               return 0;
        endcase
    endfunction

    // current byte closes the key, the previous fifteen sit in the history
    function automatic logic key_complete(input logic [7:0] cur);
        if (cur != TeleKey[KeyMaxBytes-1])
            return 1'b0;
        for (int j = 1; j < KeyMaxBytes; j++)
            if (history[j-1] != TeleKey[KeyMaxBytes-1-j])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic close_item();
        int unsigned   w;
        t_field_result res;
        w = tag_bytes(tag_byte);
        if (w != 0) begin
            res.field_tag       = tag_byte[4:0];
            res.field_value     = accum;
            res.value_width     = 4'(w);
            res.length_mismatch = (item_len != 8'(w));
            expected_fields.push_back(res);
        end
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic first, input logic last);
        logic        at_end;
        int unsigned w;
        at_end = last;
        if (first) begin
            offset = '0;
            phase  = PH_SEARCH;
        end
        if (offset >= LastOffset)
            at_end = 1'b1;

        case (phase)
            PH_SEARCH: begin
                if (offset >= 8'(KeyMaxBytes - 1) &&
                    (offset - 8'(KeyMaxBytes - 1)) < search_limit && key_complete(b)) begin
                    skip_left = skip_setting;
                    phase     = (skip_setting == 0) ? PH_TAG : PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 3'd1;
                if (skip_left == 0)
                    phase = PH_TAG;
            end
            PH_TAG: begin
                tag_byte = b;
                phase    = PH_LEN;
            end
            PH_LEN: begin
                item_len = b;
                seen     = '0;
                accum    = '0;
                if (b == 0) begin
                    close_item();
                    phase = PH_TAG;
                end else begin
                    phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                w = tag_bytes(tag_byte);
                if (seen < w)
                    accum = {accum[55:0], b};
                seen = seen + 8'd1;
                if (seen == item_len) begin
                    close_item();
                    phase = PH_TAG;
                end
            end
            default: phase = PH_SEARCH;
        endcase

        for (int i = RecentDepth - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = b;

        if (at_end) begin
            offset = '0;
            phase  = PH_SEARCH;
        end else if (offset != 8'hFF) begin
            offset = offset + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_field_result want;
        if (!i_rst_n) begin
            search_limit = KeySearchLimitReset;
            skip_setting = LengthSkipBytesReset;
            foreach (history[i])
                history[i] = '0;
            offset    = '0;
            phase     = PH_SEARCH;
            skip_left = '0;
            tag_byte  = '0;
            item_len  = '0;
            seen      = '0;
            accum     = '0;
            expected_fields.delete();
        end else begin
            // output side first: a beat accepted now cannot be answered in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (expected_fields.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected field beat: tag %0d value %h width %0d flag %0b",
                                 i_field_tag, i_field_value, i_value_width, i_length_mismatch);
                end else begin
                    want = expected_fields.pop_front();
                    if (i_field_tag !== want.field_tag || i_field_value !== want.field_value ||
                        i_value_width !== want.value_width ||
                        i_length_mismatch !== want.length_mismatch) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"field mismatch: expected tag %0d value %h width %0d ",
                                      "flag %0b, got tag %0d value %h width %0d flag %0b"},
                                     want.field_tag, want.field_value, want.value_width,
                                     want.length_mismatch, i_field_tag, i_field_value,
                                     i_value_width, i_length_mismatch);
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgKeySearchLimit:  search_limit = i_cfg_data;
                    CfgLengthSkipBytes: skip_setting = i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                predict_beat(i_data_byte, i_packet_first, i_packet_last);
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_fields.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// byte stream stimulus for the telemetry field parser, checked beat by beat
// ----------------------------------------------------------------------------
// A short directed packet hits zero-length, unknown-tag and cut-off items.
// Then random packets run through eight register settings (limit and skip
// extremes among them) and four idling patterns. Most packets are well formed:
// random prefix, telemetry key (now and then corrupted), skipped set length
// and tag/length/value items until the packet end, which may cut the last item.
// The rest is noise with stray first/last marks. The checker predicts every
// field beat and counts mismatches; this module only drives and judges.
// ----------------------------------------------------------------------------
module testbench;
    import klvp_pkg::*;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_index    = CfgKeySearchLimit;
    logic [7:0]  i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte    = '0;
    logic        i_packet_first = 1'b0;
    logic        i_packet_last  = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [4:0]  o_field_tag;
    logic [63:0] o_field_value;
    logic [3:0]  o_value_width;
    logic        o_length_mismatch;

    int fail_count;
    int pending;

    // idling controls, changed between phases
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    // register values currently in the parser, used to shape packets
    logic [7:0] cur_limit = KeySearchLimitReset;
    logic [2:0] cur_skip  = LengthSkipBytesReset;

    int         beats_sent = 0;
    logic [7:0] pkt_bytes[$];

    // recognized tags and their value widths, for well-formed lengths
    localparam logic [7:0] KnownTags [13] = '{
        8'd1, 8'd2, 8'd5, 8'd6, 8'd7, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20
    };
    localparam logic [7:0] KnownWidths [13] = '{
        8'd2, 8'd8, 8'd2, 8'd2, 8'd2, 8'd4, 8'd4, 8'd2, 8'd2, 8'd2, 8'd4, 8'd4, 8'd4
    };

    always #5 i_clk = ~i_clk;

    klv_telemetry_field_parser uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_packet_first    (i_packet_first),
        .i_packet_last     (i_packet_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_field_tag       (o_field_tag),
        .o_field_value     (o_field_value),
        .o_value_width     (o_value_width),
        .o_length_mismatch (o_length_mismatch)
    );

    klv_field_checker field_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_packet_first    (i_packet_first),
        .i_packet_last     (i_packet_last),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_field_tag       (o_field_tag),
        .i_field_value     (o_field_value),
        .i_value_width     (o_value_width),
        .i_length_mismatch (o_length_mismatch),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // one byte beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [7:0] b, input logic first, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_packet_first <= first;
        i_packet_last  <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        beats_sent++;
    endtask

    // stop sending until every predicted field beat has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        // bytes that give no field may still sit in the two-stage pipe
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] limit, input logic [2:0] skip);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgKeySearchLimit;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        i_cfg_index <= CfgLengthSkipBytes;
        i_cfg_data  <= {5'd0, skip};
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_limit = limit;
        cur_skip  = skip;
    endtask

    task automatic send_packet(input int plen, input logic mark_first, input logic mark_last);
        for (int i = 0; i < plen; i++)
            send_beat(pkt_bytes[i], mark_first && i == 0, mark_last && i == plen - 1);
    endtask

    // append one tag/length/value item, usually with the tag's own width
    task automatic add_item();
        int         k;
        int         fill;
        logic [7:0] tag;
        logic [7:0] len;
        int         pick;
        k    = $urandom_range(12);
        tag  = ($urandom_range(4) != 0) ? KnownTags[k] : 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 60)
            len = KnownWidths[k];
        else if (pick < 70)
            len = 8'd0;
        else if (pick < 95)
            len = 8'($urandom_range(1, 9));
        else
            len = 8'($urandom_range(10, 255));
        fill = $urandom_range(5);
        pkt_bytes.push_back(tag);
        pkt_bytes.push_back(len);
        for (int i = 0; i < len; i++) begin
            case (fill)
                0:       pkt_bytes.push_back(8'h00);
                1:       pkt_bytes.push_back(8'hFF);
                default: pkt_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    task automatic random_packet();
        int   plen;
        int   prefix;
        int   bad;
        logic mark_first;
        logic mark_last;
        pkt_bytes.delete();
        if ($urandom_range(99) < 15) begin
            // noise with stray packet marks
            plen = $urandom_range(1, 24);
            for (int i = 0; i < plen; i++)
                send_beat(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
        end else begin
            plen = ($urandom_range(99) < 8) ? $urandom_range(188, 200) : $urandom_range(20, 80);
            if ($urandom_range(3) == 0)
                prefix = $urandom_range(0, int'(cur_limit) + 2);
            else
                prefix = $urandom_range(0, 3);
            for (int i = 0; i < prefix; i++)
                pkt_bytes.push_back(8'($urandom));
            bad = ($urandom_range(9) == 0) ? $urandom_range(15) : -1;
            for (int i = 0; i < KeyMaxBytes; i++)
                pkt_bytes.push_back((i == bad) ? TeleKey[i] ^ 8'(1 << $urandom_range(7))
                                               : TeleKey[i]);
            for (int i = 0; i < cur_skip; i++)
                pkt_bytes.push_back(8'($urandom));
            while (pkt_bytes.size() < plen)
                add_item();
            mark_first = ($urandom_range(19) != 0);
            // full-size packets often end on the length limit alone
            mark_last  = (plen < 188) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
            send_packet(plen, mark_first, mark_last);
        end
    endtask

    // key at offset zero, no skip: zero-length item, unknown tag, full item,
    // then an item cut off by the packet end
    task automatic directed_packet();
        pkt_bytes.delete();
        for (int i = 0; i < KeyMaxBytes; i++)
            pkt_bytes.push_back(TeleKey[i]);
        pkt_bytes.push_back(8'h02);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'hAB);
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'h02);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h14);
        pkt_bytes.push_back(8'h05);
        pkt_bytes.push_back(8'h00);
        send_packet(pkt_bytes.size(), 1'b1, 1'b1);
    endtask

    initial begin : stimulus
        logic [7:0] limits [8];
        logic [2:0] skips  [8];
        int         target;
        logic       paused;
        limits = '{8'd100, 8'd0, 8'd184, 8'd1, 8'd184, 8'($urandom_range(2, 183)), 8'd50, 8'd16};
        skips  = '{3'd2, 3'd0, 3'd4, 3'd4, 3'd0, 3'd3, 3'd1, 3'($urandom_range(4))};
        paused = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(8'd184, 3'd0);
        directed_packet();

        for (int p = 0; p < 8; p++) begin
            // idling pattern: none, sender only, receiver only, both lightly
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
                default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
            endcase
            configure(limits[p], skips[p]);
            target = beats_sent + 200;
            while (beats_sent < target) begin
                random_packet();
                if (p == 1 && !paused && beats_sent > target - 100) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
